/* rtl/core/qrao_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrao_pkg
// Shared types, widths and helpers for the quadratic roots block.
// ----------------------------------------------------------------------------
package qrao_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int COEF_W        = 32;
  localparam int EPS_W         = 31;
  localparam int DISC_W        = 67;  // signed discriminant, magnitude below 2^66
  localparam int ROOT_W        = 34;  // floor sqrt of the discriminant
  localparam int DEN_W         = 33;  // magnitude of 2p
  localparam int REM_W         = 65;  // divider remainder, holds den << 32
  localparam int QUO_W         = 32;
  localparam int N_ORDER       = 6;
  localparam int ORD_W         = 3;
  localparam int SQ_CELLS      = 34;
  localparam int DV_CELLS      = 32;

  localparam logic [ORD_W-1:0] ORD_LAST = ORD_W'(N_ORDER - 1);

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DEGEN = 2'd1;
  localparam logic [1:0] ST_NOREAL = 2'd2;

  localparam logic [1:0] ROLE_P = 2'd0;
  localparam logic [1:0] ROLE_Q = 2'd1;
  localparam logic [1:0] ROLE_R = 2'd2;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef_a;
    logic signed [COEF_W-1:0] coef_b;
    logic signed [COEF_W-1:0] coef_c;
  } in_word_t;

  typedef struct packed {
    logic [ORD_W-1:0]         order_index;
    logic [1:0]               status;
    logic signed [COEF_W-1:0] root_plus;
    logic signed [COEF_W-1:0] root_minus;
    logic                     last;
  } out_word_t;

  // side data riding along the square root chain
  typedef struct packed {
    logic signed [COEF_W-1:0] p;
    logic signed [COEF_W-1:0] q;
    logic [ORD_W-1:0]         idx;
    logic                     last;
    logic [1:0]               status;
  } sq_side_t;

  // side data riding along the divider chain
  typedef struct packed {
    logic [ORD_W-1:0] idx;
    logic             last;
    logic [1:0]       status;
    logic             neg_p;
    logic             neg_n;
    logic             ovf_p;
    logic             ovf_n;
  } dv_side_t;

  // coefficient taken for one role of one ordering (abc,acb,bac,bca,cab,cba)
  function automatic logic signed [COEF_W-1:0] pick_coef(in_word_t w,
                                                         logic [ORD_W-1:0] n,
                                                         logic [1:0] role);
    logic [1:0] k;
    k = 2'd0;
    case (n)
      3'd0: k = (role == ROLE_P) ? 2'd0 : (role == ROLE_Q) ? 2'd1 : 2'd2;
      3'd1: k = (role == ROLE_P) ? 2'd0 : (role == ROLE_Q) ? 2'd2 : 2'd1;
      3'd2: k = (role == ROLE_P) ? 2'd1 : (role == ROLE_Q) ? 2'd0 : 2'd2;
      3'd3: k = (role == ROLE_P) ? 2'd1 : (role == ROLE_Q) ? 2'd2 : 2'd0;
      3'd4: k = (role == ROLE_P) ? 2'd2 : (role == ROLE_Q) ? 2'd0 : 2'd1;
      3'd5: k = (role == ROLE_P) ? 2'd2 : (role == ROLE_Q) ? 2'd1 : 2'd0;
      default: k = 2'd0;
    endcase
    case (k)
      2'd0:    return w.coef_a;
      2'd1:    return w.coef_b;
      default: return w.coef_c;
    endcase
  endfunction

endpackage

/* rtl/core/quadratic_roots_all_orderings.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_roots_all_orderings
// Solves p*x^2+q*x+r=0 for all six orderings of three fixed-point coefficients.
// ----------------------------------------------------------------------------
// Each input word yields six result words, one per ordering (abc, acb, bac,
// bca, cab, cba), issued one per cycle into a single pipeline except while it
// holds; the next input word is accepted during the sixth ordering of the
// current one. The one-result-per-cycle output channel sets that rate.
// From issue to result an ordering passes three front stages (coefficient
// select, multiply, discriminant), a chain of 34 square root cells, one
// divider setup stage, a chain of 32 divider cells and the output register.
// The whole pipeline holds while a result waits at the output. eps may only
// be written while the block is idle.
// ----------------------------------------------------------------------------
module quadratic_roots_all_orderings #(
  parameter int FRAC_BITS = qrao_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  qrao_pkg::in_word_t            in_word,
  output logic                          out_valid,
  input  logic                          out_ready,
  output qrao_pkg::out_word_t           out_word,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [qrao_pkg::EPS_W-1:0]    cfg_eps
);

  localparam int CW = qrao_pkg::COEF_W;
  localparam int DW = qrao_pkg::DISC_W;
  localparam int RW = qrao_pkg::REM_W;
  localparam int QW = qrao_pkg::QUO_W;
  localparam int NW = qrao_pkg::ROOT_W + 1;

  function automatic logic signed [CW-1:0] sat_root(logic [QW-1:0] mag, logic neg,
                                                    logic ovf);
    logic signed [CW-1:0] v;
    if (ovf) begin
      v = neg ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end else if (neg) begin
      v = (mag > {1'b1, {(QW-1){1'b0}}}) ? {1'b1, {(CW-1){1'b0}}} : -$signed(mag);
    end else begin
      v = mag[QW-1] ? {1'b0, {(CW-1){1'b1}}} : $signed(mag);
    end
    return v;
  endfunction

  logic en;
  assign en = !out_valid || out_ready;

  // eps register
  logic [qrao_pkg::EPS_W-1:0] eps_r;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= qrao_pkg::EPS_W'(1) << FRAC_BITS;
    end else if (cfg_valid && cfg_ready) begin
      eps_r <= cfg_eps;
    end
  end

  // ordering issuer
  logic                         busy_r;
  logic [qrao_pkg::ORD_W-1:0]   n_r;
  qrao_pkg::in_word_t           coef_r;
  logic                         in_acc;

  assign in_ready = !busy_r || (n_r == qrao_pkg::ORD_LAST && en);
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      n_r    <= '0;
    end else if (in_acc) begin
      busy_r <= 1'b1;
      n_r    <= '0;
    end else if (en && busy_r) begin
      if (n_r == qrao_pkg::ORD_LAST) begin
        busy_r <= 1'b0;
      end
      n_r <= n_r + qrao_pkg::ORD_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      coef_r <= in_word;
    end
  end

  // stage 1: pick p, q, r
  logic                       v1_r;
  logic signed [CW-1:0]       p1_r, q1_r, r1_r;
  logic [qrao_pkg::ORD_W-1:0] idx1_r;
  logic                       last1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= busy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r    <= qrao_pkg::pick_coef(coef_r, n_r, qrao_pkg::ROLE_P);
      q1_r    <= qrao_pkg::pick_coef(coef_r, n_r, qrao_pkg::ROLE_Q);
      r1_r    <= qrao_pkg::pick_coef(coef_r, n_r, qrao_pkg::ROLE_R);
      idx1_r  <= n_r;
      last1_r <= (n_r == qrao_pkg::ORD_LAST);
    end
  end

  // near-zero leading coefficient
  logic [CW-1:0] pm1;
  logic          deg1;
  assign pm1  = p1_r[CW-1] ? CW'(-p1_r) : CW'(p1_r);
  assign deg1 = (pm1 < CW'(eps_r)) || (pm1 == '0);

  // stage 2: products q*q and p*r
  logic                       v2_r;
  logic signed [2*CW-1:0]     qq2_r, pr2_r;
  logic signed [CW-1:0]       p2_r, q2_r;
  logic [qrao_pkg::ORD_W-1:0] idx2_r;
  logic                       last2_r, deg2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qq2_r   <= q1_r * q1_r;
      pr2_r   <= p1_r * r1_r;
      p2_r    <= p1_r;
      q2_r    <= q1_r;
      idx2_r  <= idx1_r;
      last2_r <= last1_r;
      deg2_r  <= deg1;
    end
  end

  // stage 3: discriminant and status
  logic signed [DW-1:0] disc2;
  assign disc2 = DW'(qq2_r) - (DW'(pr2_r) <<< 2);

  logic                v3_r;
  qrao_pkg::sq_side_t  side3_r;
  logic [DW-1:0]       x3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side3_r.p    <= p2_r;
      side3_r.q    <= q2_r;
      side3_r.idx  <= idx2_r;
      side3_r.last <= last2_r;
      side3_r.status <= deg2_r ? qrao_pkg::ST_DEGEN :
                        disc2[DW-1] ? qrao_pkg::ST_NOREAL : qrao_pkg::ST_OK;
      x3_r         <= disc2;
    end
  end

  // square root chain
  logic               sq_v    [0:qrao_pkg::SQ_CELLS];
  qrao_pkg::sq_side_t sq_side [0:qrao_pkg::SQ_CELLS];
  logic [DW-1:0]      sq_x    [0:qrao_pkg::SQ_CELLS];
  logic [DW-1:0]      sq_res  [0:qrao_pkg::SQ_CELLS];

  assign sq_v[0]    = v3_r;
  assign sq_side[0] = side3_r;
  assign sq_x[0]    = x3_r;
  assign sq_res[0]  = '0;

  for (genvar k = 0; k < qrao_pkg::SQ_CELLS; k++) begin : g_sq
    qrao_sqrt_cell #(.BIT(qrao_pkg::SQ_CELLS - 1 - k)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .v_in    (sq_v[k]),
      .side_in (sq_side[k]),
      .x_in    (sq_x[k]),
      .res_in  (sq_res[k]),
      .v_r     (sq_v[k+1]),
      .side_r  (sq_side[k+1]),
      .x_r     (sq_x[k+1]),
      .res_r   (sq_res[k+1])
    );
  end

  // divider setup: numerators -q +/- s scaled, divisor |2p|
  qrao_pkg::sq_side_t    sq_o;
  logic [qrao_pkg::ROOT_W-1:0] s_root;
  logic signed [NW-1:0]  q_ext, num_p, num_n;
  logic [NW-1:0]         mag_p, mag_n;
  logic signed [qrao_pkg::DEN_W-1:0] den;
  logic [qrao_pkg::DEN_W-1:0] dm;
  logic [RW-1:0]         nm_p, nm_n, dlim;

  always_comb begin
    sq_o   = sq_side[qrao_pkg::SQ_CELLS];
    s_root = sq_res[qrao_pkg::SQ_CELLS][qrao_pkg::ROOT_W-1:0];
    q_ext  = NW'(sq_o.q);
    num_p  = -q_ext + $signed({1'b0, s_root});
    num_n  = -q_ext - $signed({1'b0, s_root});
    mag_p  = num_p[NW-1] ? NW'(-num_p) : NW'(num_p);
    mag_n  = num_n[NW-1] ? NW'(-num_n) : NW'(num_n);
    den    = qrao_pkg::DEN_W'(sq_o.p) <<< 1;
    dm     = den[qrao_pkg::DEN_W-1] ? qrao_pkg::DEN_W'(-den) : qrao_pkg::DEN_W'(den);
    nm_p   = RW'(mag_p) << FRAC_BITS;
    nm_n   = RW'(mag_n) << FRAC_BITS;
    dlim   = RW'(dm) << QW;
  end

  logic               v4_r;
  qrao_pkg::dv_side_t side4_r;
  logic [qrao_pkg::DEN_W-1:0] dm4_r;
  logic [RW-1:0]      nm_p4_r, nm_n4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= sq_v[qrao_pkg::SQ_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side4_r.idx    <= sq_o.idx;
      side4_r.last   <= sq_o.last;
      side4_r.status <= sq_o.status;
      side4_r.neg_p  <= num_p[NW-1] ^ sq_o.p[CW-1];
      side4_r.neg_n  <= num_n[NW-1] ^ sq_o.p[CW-1];
      side4_r.ovf_p  <= (nm_p >= dlim);
      side4_r.ovf_n  <= (nm_n >= dlim);
      dm4_r          <= dm;
      nm_p4_r        <= nm_p;
      nm_n4_r        <= nm_n;
    end
  end

  // divider chain
  logic               dv_v    [0:qrao_pkg::DV_CELLS];
  qrao_pkg::dv_side_t dv_side [0:qrao_pkg::DV_CELLS];
  logic [qrao_pkg::DEN_W-1:0] dv_dm [0:qrao_pkg::DV_CELLS];
  logic [RW-1:0]      dv_rp   [0:qrao_pkg::DV_CELLS];
  logic [RW-1:0]      dv_rn   [0:qrao_pkg::DV_CELLS];
  logic [QW-1:0]      dv_qp   [0:qrao_pkg::DV_CELLS];
  logic [QW-1:0]      dv_qn   [0:qrao_pkg::DV_CELLS];

  assign dv_v[0]    = v4_r;
  assign dv_side[0] = side4_r;
  assign dv_dm[0]   = dm4_r;
  assign dv_rp[0]   = nm_p4_r;
  assign dv_rn[0]   = nm_n4_r;
  assign dv_qp[0]   = '0;
  assign dv_qn[0]   = '0;

  for (genvar j = 0; j < qrao_pkg::DV_CELLS; j++) begin : g_dv
    qrao_div_cell #(.BIT(qrao_pkg::DV_CELLS - 1 - j)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .v_in     (dv_v[j]),
      .side_in  (dv_side[j]),
      .dm_in    (dv_dm[j]),
      .rem_p_in (dv_rp[j]),
      .rem_n_in (dv_rn[j]),
      .quo_p_in (dv_qp[j]),
      .quo_n_in (dv_qn[j]),
      .v_r      (dv_v[j+1]),
      .side_r   (dv_side[j+1]),
      .dm_r     (dv_dm[j+1]),
      .rem_p_r  (dv_rp[j+1]),
      .rem_n_r  (dv_rn[j+1]),
      .quo_p_r  (dv_qp[j+1]),
      .quo_n_r  (dv_qn[j+1])
    );
  end

  // saturation and output register
  qrao_pkg::dv_side_t  dv_o;
  qrao_pkg::out_word_t res_nxt;
  logic                out_valid_r;
  qrao_pkg::out_word_t out_word_r;

  always_comb begin
    dv_o                = dv_side[qrao_pkg::DV_CELLS];
    res_nxt.order_index = dv_o.idx;
    res_nxt.status      = dv_o.status;
    res_nxt.last        = dv_o.last;
    if (dv_o.status == qrao_pkg::ST_OK) begin
      res_nxt.root_plus  = sat_root(dv_qp[qrao_pkg::DV_CELLS], dv_o.neg_p, dv_o.ovf_p);
      res_nxt.root_minus = sat_root(dv_qn[qrao_pkg::DV_CELLS], dv_o.neg_n, dv_o.ovf_n);
    end else begin
      res_nxt.root_plus  = '0;
      res_nxt.root_minus = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_v[qrao_pkg::DV_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_word_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

/* rtl/core/qrao_sqrt_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrao_sqrt_cell
// One bit of the restoring square root: trial subtract of res + 4^BIT.
// ----------------------------------------------------------------------------
module qrao_sqrt_cell #(
  parameter int BIT = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          v_in,
  input  qrao_pkg::sq_side_t            side_in,
  input  logic [qrao_pkg::DISC_W-1:0]   x_in,
  input  logic [qrao_pkg::DISC_W-1:0]   res_in,
  output logic                          v_r,
  output qrao_pkg::sq_side_t            side_r,
  output logic [qrao_pkg::DISC_W-1:0]   x_r,
  output logic [qrao_pkg::DISC_W-1:0]   res_r
);

  localparam logic [qrao_pkg::DISC_W-1:0] ONE =
    qrao_pkg::DISC_W'(1) << (2 * BIT);

  logic [qrao_pkg::DISC_W-1:0] trial;
  logic [qrao_pkg::DISC_W-1:0] x_nxt;
  logic [qrao_pkg::DISC_W-1:0] res_nxt;

  // trial subtract
  always_comb begin
    trial = res_in + ONE;
    if (x_in >= trial) begin
      x_nxt   = x_in - trial;
      res_nxt = (res_in >> 1) + ONE;
    end else begin
      x_nxt   = x_in;
      res_nxt = res_in >> 1;
    end
  end

  // valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_in;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= side_in;
      x_r    <= x_nxt;
      res_r  <= res_nxt;
    end
  end

endmodule

/* rtl/core/qrao_div_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrao_div_cell
// One quotient bit of two restoring divisions sharing one divisor.
// ----------------------------------------------------------------------------
module qrao_div_cell #(
  parameter int BIT = 0
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         v_in,
  input  qrao_pkg::dv_side_t           side_in,
  input  logic [qrao_pkg::DEN_W-1:0]   dm_in,
  input  logic [qrao_pkg::REM_W-1:0]   rem_p_in,
  input  logic [qrao_pkg::REM_W-1:0]   rem_n_in,
  input  logic [qrao_pkg::QUO_W-1:0]   quo_p_in,
  input  logic [qrao_pkg::QUO_W-1:0]   quo_n_in,
  output logic                         v_r,
  output qrao_pkg::dv_side_t           side_r,
  output logic [qrao_pkg::DEN_W-1:0]   dm_r,
  output logic [qrao_pkg::REM_W-1:0]   rem_p_r,
  output logic [qrao_pkg::REM_W-1:0]   rem_n_r,
  output logic [qrao_pkg::QUO_W-1:0]   quo_p_r,
  output logic [qrao_pkg::QUO_W-1:0]   quo_n_r
);

  localparam logic [qrao_pkg::QUO_W-1:0] QBIT = qrao_pkg::QUO_W'(1) << BIT;

  logic [qrao_pkg::REM_W-1:0] sh;
  logic [qrao_pkg::REM_W-1:0] rem_p_nxt;
  logic [qrao_pkg::REM_W-1:0] rem_n_nxt;
  logic [qrao_pkg::QUO_W-1:0] quo_p_nxt;
  logic [qrao_pkg::QUO_W-1:0] quo_n_nxt;

  // shifted divisor, trial subtract on both numerators
  always_comb begin
    sh = qrao_pkg::REM_W'(dm_in) << BIT;
    rem_p_nxt = rem_p_in;
    quo_p_nxt = quo_p_in;
    rem_n_nxt = rem_n_in;
    quo_n_nxt = quo_n_in;
    if (rem_p_in >= sh) begin
      rem_p_nxt = rem_p_in - sh;
      quo_p_nxt = quo_p_in | QBIT;
    end
    if (rem_n_in >= sh) begin
      rem_n_nxt = rem_n_in - sh;
      quo_n_nxt = quo_n_in | QBIT;
    end
  end

  // valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_in;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      side_r  <= side_in;
      dm_r    <= dm_in;
      rem_p_r <= rem_p_nxt;
      rem_n_r <= rem_n_nxt;
      quo_p_r <= quo_p_nxt;
      quo_n_r <= quo_n_nxt;
    end
  end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the six-ordering quadratic roots block.
// ----------------------------------------------------------------------------
// Directed words from a table (extremes, degenerate leading coefficients,
// negative and zero discriminants, saturation) are followed by random words,
// mostly small well-conditioned coefficients with some raw noise. Every
// result word is checked against a bit-exact predictor. eps is rewritten
// between phases, only once the block has drained.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int LATENCY = 80;
  localparam int WD_LIMIT = 4000;
  localparam int N_DIR = 14;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  qrao_pkg::in_word_t in_word;
  qrao_pkg::out_word_t out_word;
  logic [qrao_pkg::EPS_W-1:0] cfg_eps;

  logic [qrao_pkg::EPS_W-1:0] eps_model;
  qrao_pkg::out_word_t pending_roots[$];
  int errors, n_words, n_results, idle_cycles;
  bit quiet;

  quadratic_roots_all_orderings u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_eps(cfg_eps)
  );

  always begin
    clk = 1'b0; #6;
    clk = 1'b1; #6;
  end

  // floor square root of a value below 2^66
  function automatic logic [33:0] isqrt66(logic [66:0] d);
    logic [33:0] s, c;
    logic [67:0] sq;
    s = '0;
    for (int b = 33; b >= 0; b--) begin
      c = s | (34'd1 << b);
      sq = c * c;
      if (sq <= {1'b0, d}) s = c;
    end
    return s;
  endfunction

  function automatic logic signed [31:0] sat_quot(logic signed [127:0] num,
                                                  logic signed [127:0] den);
    logic signed [127:0] v;
    v = (num <<< 16) / den;
    if (v > 128'sd2147483647) return 32'sh7fffffff;
    if (v < -128'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // expected six result words for one coefficient word
  task automatic predict_roots(qrao_pkg::in_word_t w);
    logic signed [31:0] co[3];
    logic signed [127:0] p, q, r, d, s;
    logic [127:0] pm;
    int perm[6][3];
    qrao_pkg::out_word_t o;
    perm = '{'{0,1,2}, '{0,2,1}, '{1,0,2}, '{1,2,0}, '{2,0,1}, '{2,1,0}};
    co[0] = w.coef_a; co[1] = w.coef_b; co[2] = w.coef_c;
    for (int n = 0; n < qrao_pkg::N_ORDER; n++) begin
      p = co[perm[n][0]]; q = co[perm[n][1]]; r = co[perm[n][2]];
      pm = (p < 0) ? -p : p;
      o = '0;
      o.order_index = qrao_pkg::ORD_W'(n);
      o.last = (n == qrao_pkg::N_ORDER - 1);
      if (pm < eps_model || pm == 0) begin
        o.status = qrao_pkg::ST_DEGEN;
      end else begin
        d = q * q - 4 * p * r;
        if (d < 0) begin
          o.status = qrao_pkg::ST_NOREAL;
        end else begin
          s = isqrt66(d[66:0]);
          o.status = qrao_pkg::ST_OK;
          o.root_plus = sat_quot(-q + s, 2 * p);
          o.root_minus = sat_quot(-q - s, 2 * p);
        end
      end
      pending_roots.push_back(o);
    end
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("mismatch %s: got %0h want %0h", what, got, want);
  endtask

  task automatic random_gap(int pct);
    if (!quiet && $urandom_range(99) < pct) repeat ($urandom_range(12, 1)) @(negedge clk);
  endtask

  // result side: random stalls, compare against oldest expectation
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready = quiet ? 1'b1 : ($urandom_range(99) < 75);
      if (!out_ready && !quiet) begin
        repeat ($urandom_range(12, 1) - 1) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (pending_roots.size() == 0) begin
        report_mismatch("unexpected word", 64'(out_word.order_index), 64'd0);
      end else begin
        qrao_pkg::out_word_t e;
        e = pending_roots.pop_front();
        if (out_word.order_index !== e.order_index)
          report_mismatch("order_index", 64'(out_word.order_index), 64'(e.order_index));
        if (out_word.status !== e.status)
          report_mismatch("status", 64'(out_word.status), 64'(e.status));
        if (out_word.root_plus !== e.root_plus)
          report_mismatch("root_plus", 64'(out_word.root_plus), 64'(e.root_plus));
        if (out_word.root_minus !== e.root_minus)
          report_mismatch("root_minus", 64'(out_word.root_minus), 64'(e.root_minus));
        if (out_word.last !== e.last)
          report_mismatch("last", 64'(out_word.last), 64'(e.last));
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
        || !rst_n)
      idle_cycles = 0;
    else begin
      idle_cycles++;
      if (idle_cycles >= WD_LIMIT) begin
        $display("watchdog expired");
        $display("[quadratic_roots_all_orderings] ERROR");
        $finish;
      end
    end
  end

  task automatic send_word(qrao_pkg::in_word_t w);
    random_gap(20);
    in_word = w;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_roots(w);
    n_words++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic write_eps(logic [qrao_pkg::EPS_W-1:0] v);
    while (pending_roots.size() != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
    cfg_eps = v;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    eps_model = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(9))
      0: return $urandom();
      1: return 32'h80000000 | $urandom_range(3);
      2: return 32'h7ffffffc | $urandom_range(3);
      3: return $urandom_range(3);
      default: return 32'($signed($urandom_range(1 << 22)) - (1 << 21));
    endcase
  endfunction

  qrao_pkg::in_word_t directed[N_DIR];
  logic [qrao_pkg::EPS_W-1:0] eps_set[5];
  qrao_pkg::in_word_t w;

  initial begin
    errors = 0; n_words = 0; n_results = 0; idle_cycles = 0; quiet = 0;
    rst_n = 1'b0; in_valid = 1'b0; in_word = '0; cfg_valid = 1'b0; cfg_eps = '0;
    eps_model = qrao_pkg::EPS_W'(1 << 16);
    directed = '{
      '{32'sh00010000, 32'shfffd0000, 32'sh00020000},  // roots 2 and 1
      '{32'sh00010000, 32'sh00020000, 32'sh00010000},  // zero discriminant
      '{32'sh00010000, 32'sh00000000, 32'sh00010000},  // no real roots
      '{32'sh00000000, 32'sh00000000, 32'sh00000000},  // all degenerate
      '{32'sh0000ffff, 32'sh00010000, 32'shffff0001},  // just under eps
      '{32'sh80000000, 32'sh80000000, 32'sh80000000},
      '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff},
      '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff},
      '{32'sh80000000, 32'sh7fffffff, 32'sh00000001},  // saturation
      '{32'sh00000001, 32'sh7fffffff, 32'sh80000000},
      '{32'shffffffff, 32'sh00000000, 32'sh00000000},
      '{32'sh00010000, 32'sh00000000, 32'shffff0000},
      '{32'shfffe0000, 32'sh00050000, 32'sh00030000},
      '{32'sh00008000, 32'sh00000001, 32'shffffffff}
    };
    eps_set = '{31'd0, 31'h7fffffff, 31'd1, 31'd4096, 31'd65536};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset value of eps first, then the table at zero eps, four words at max eps
    for (int i = 0; i < N_DIR; i++) send_word(directed[i]);
    write_eps(31'd0);
    for (int i = 0; i < N_DIR; i++) send_word(directed[i]);
    write_eps(31'h7fffffff);
    for (int i = 0; i < 4; i++) send_word(directed[i]);

    // random phases, one eps setting each; the last phase runs flat out
    for (int ph = 0; ph < 5; ph++) begin
      write_eps(ph == 4 ? 31'($urandom()) : eps_set[ph]);
      if (ph == 4) quiet = 1;
      for (int i = 0; i < 85; i++) begin
        w.coef_a = rand_coef(); w.coef_b = rand_coef(); w.coef_c = rand_coef();
        send_word(w);
      end
    end

    while (pending_roots.size() != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
    $display("covered %0d coefficient words, %0d result words, eps across six settings",
             n_words, n_results);
    if (errors == 0)
      $display("[quadratic_roots_all_orderings] OK");
    else
      $display("[quadratic_roots_all_orderings] ERROR");
    $finish;
  end
endmodule
